### hw/rtl/aabbfc_pkg.sv
// Shared types and constants for the box frustum culling block.
package aabbfc_pkg;

    localparam int PLANE_COUNT_DEF = 6;
    localparam int PLANE_SLOTS     = 6;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_ADDR_W      = $clog2(PLANE_SLOTS * 8);
    localparam int REG_IDX_W       = CFG_ADDR_W - 3;
    localparam int DIST_W          = 35;

    localparam logic [REG_IDX_W-1:0] REG_PLANE_ZERO = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_PLANE_FIVE = REG_IDX_W'(PLANE_SLOTS - 1);

    typedef struct packed {
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] min_z;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
        logic signed [15:0] max_z;
        logic               last_box;
    } t_box_in;

    typedef struct packed {
        logic culled;
        logic last_result;
    } t_box_out;

    typedef struct packed {
        logic signed [15:0] d;
        logic signed [15:0] nz;
        logic signed [15:0] ny;
        logic signed [15:0] nx;
    } t_plane;

    typedef struct packed {
        t_box_in box;
        logic    culled;
    } t_flow;

    // coordinate of the corner farthest along the normal on one axis
    function automatic logic signed [15:0] far_coord(
        input logic signed [15:0] n,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic lo_gt_hi;
        lo_gt_hi = (lo > hi);
        if (n[15]) begin
            far_coord = lo_gt_hi ? hi : lo;
        end else begin
            far_coord = lo_gt_hi ? lo : hi;
        end
    endfunction

endpackage

### hw/rtl/aabb_frustum_cull.sv
// Top level: plane registers, chain of plane cells and output register.
// Takes one box per cycle when the output side keeps up. Each box walks a chain of
// PLANE_COUNT cells, two register stages per cell (corner pick and multiply, then sum and
// sign test), plus one output register. Stalls hold items in place stage by stage; empty
// stages still fill. Planes sit at byte addresses 8*i, 64 bits each; the user must write
// them only while idle, which the block itself does not enforce.
module aabb_frustum_cull #(
    parameter int PLANE_COUNT = aabbfc_pkg::PLANE_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  aabbfc_pkg::t_box_in                 i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output aabbfc_pkg::t_box_out                o_out_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [aabbfc_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [aabbfc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [aabbfc_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                                pready
);

    logic [aabbfc_pkg::CFG_DATA_W-1:0] r_plane [aabbfc_pkg::PLANE_SLOTS];
    logic                              r_out_valid;
    aabbfc_pkg::t_box_out              r_out_item;

    logic [aabbfc_pkg::REG_IDX_W-1:0]  reg_idx;
    logic                              idx_ok;
    logic                              chain_valid [PLANE_COUNT+1];
    logic                              chain_ready [PLANE_COUNT+1];
    aabbfc_pkg::t_flow                 chain_flow  [PLANE_COUNT+1];

    assign reg_idx = paddr[aabbfc_pkg::CFG_ADDR_W-1:3];
    assign idx_ok  = (reg_idx <= aabbfc_pkg::REG_PLANE_FIVE);
    assign pready  = 1'b1;
    assign prdata  = idx_ok ? r_plane[reg_idx] : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < aabbfc_pkg::PLANE_SLOTS; i++) begin
                r_plane[i] <= '0;
            end
        end else if (psel && penable && pwrite && idx_ok) begin
            r_plane[reg_idx] <= pwdata;
        end
    end

    assign chain_valid[0]       = i_in_valid;
    assign chain_flow[0].box    = i_in_item;
    assign chain_flow[0].culled = 1'b0;
    assign o_in_ready           = chain_ready[0];

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        aabbfc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_plane (aabbfc_pkg::t_plane'(r_plane[g])),
            .i_valid (chain_valid[g]),
            .i_flow  (chain_flow[g]),
            .o_ready (chain_ready[g]),
            .o_valid (chain_valid[g+1]),
            .o_flow  (chain_flow[g+1]),
            .i_ready (chain_ready[g+1])
        );
    end

    assign chain_ready[PLANE_COUNT] = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (chain_ready[PLANE_COUNT]) begin
            r_out_valid <= chain_valid[PLANE_COUNT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (chain_ready[PLANE_COUNT] && chain_valid[PLANE_COUNT]) begin
            r_out_item.culled      <= chain_flow[PLANE_COUNT].culled;
            r_out_item.last_result <= chain_flow[PLANE_COUNT].box.last_box;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

### hw/rtl/aabbfc_cell.sv
// One plane test cell: picks the farthest corner, multiplies, sums and flags.
module aabbfc_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  aabbfc_pkg::t_plane    i_plane,
    input  logic                  i_valid,
    input  aabbfc_pkg::t_flow     i_flow,
    output logic                  o_ready,
    output logic                  o_valid,
    output aabbfc_pkg::t_flow     o_flow,
    input  logic                  i_ready
);

    logic                            r_v1;
    aabbfc_pkg::t_flow               r_flow1;
    logic signed [31:0]              r_px;
    logic signed [31:0]              r_py;
    logic signed [31:0]              r_pz;
    logic                            r_v2;
    aabbfc_pkg::t_flow               r_flow2;

    logic                            ready1;
    logic                            ready2;
    logic signed [15:0]              cx;
    logic signed [15:0]              cy;
    logic signed [15:0]              cz;
    logic signed [aabbfc_pkg::DIST_W-1:0] far_dist;
    aabbfc_pkg::t_flow               n_flow2;

    assign ready2  = !r_v2 || i_ready;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;
    assign o_valid = r_v2;
    assign o_flow  = r_flow2;

    always_comb begin
        cx = aabbfc_pkg::far_coord(i_plane.nx, i_flow.box.min_x, i_flow.box.max_x);
        cy = aabbfc_pkg::far_coord(i_plane.ny, i_flow.box.min_y, i_flow.box.max_y);
        cz = aabbfc_pkg::far_coord(i_plane.nz, i_flow.box.min_z, i_flow.box.max_z);
    end

    always_comb begin
        far_dist = {{3{r_px[31]}}, r_px} + {{3{r_py[31]}}, r_py} + {{3{r_pz[31]}}, r_pz}
                 + {{5{i_plane.d[15]}}, i_plane.d, 14'b0};
        n_flow2        = r_flow1;
        n_flow2.culled = r_flow1.culled || far_dist[aabbfc_pkg::DIST_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r_flow1 <= i_flow;
            r_px    <= i_plane.nx * cx;
            r_py    <= i_plane.ny * cy;
            r_pz    <= i_plane.nz * cz;
        end
        if (ready2 && r_v1) begin
            r_flow2 <= n_flow2;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !i_ready |=> r_v2 && $stable(r_flow2))
        else $error("cell output changed while stalled");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && ready2 && r_flow1.culled |=> r_flow2.culled)
        else $error("cull flag dropped in cell");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_v1 && !r_v2)
        else $error("cell valid set after reset");

endmodule

### test/testbench.sv
// Self-checking bench for aabb_frustum_cull: streams boxes under varied planes, predicts culling.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import aabbfc_pkg::*;

    localparam int LATENCY         = 2 * PLANE_COUNT_DEF + 1;
    localparam int SETTLE_CYCLES   = LATENCY + 4;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int LONG_HOLD       = 400;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int RANDOM_PHASES   = 9;
    localparam int PRESSURE_PHASE  = 3;
    localparam int PLANE_ADDR_STEP = 8;
    localparam int REG_SPARE_SIX   = PLANE_SLOTS;
    localparam int REG_SPARE_SEVEN = PLANE_SLOTS + 1;
    localparam int ONE_Q14         = 16384;

    typedef enum int {PLANES_FRUSTUM, PLANES_RANDOM, PLANES_EXTREME} t_plane_mix;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    t_box_in                 i_in_item = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    t_box_out                o_out_item;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [CFG_ADDR_W-1:0]   paddr;
    logic [CFG_DATA_W-1:0]   pwdata;
    logic [CFG_DATA_W-1:0]   prdata;
    logic                    pready;

    logic [63:0] plane_regs [PLANE_SLOTS];
    t_box_in     box_queue [$];
    t_box_out    cull_expect [$];
    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          send_idle = 1'b0;
    bit          recv_idle = 1'b0;
    bit          hold_request = 1'b0;

    wire in_fire  = i_in_valid && o_in_ready;
    wire out_fire = o_out_valid && i_out_ready;

    aabb_frustum_cull #(.PLANE_COUNT(PLANE_COUNT_DEF)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // a box is culled when some plane has all eight corners strictly behind it
    function automatic logic box_is_culled(input t_box_in b);
        t_plane pl;
        longint nx, ny, nz, dd, px, py, pz;
        bit     behind;
        for (int p = 0; p < PLANE_COUNT_DEF; p++) begin
            pl = t_plane'(plane_regs[p]);
            nx = longint'($signed(pl.nx));
            ny = longint'($signed(pl.ny));
            nz = longint'($signed(pl.nz));
            dd = longint'($signed(pl.d)) * ONE_Q14;
            behind = 1'b1;
            for (int k = 0; k < 8; k++) begin
                px = (k & 1) ? longint'($signed(b.max_x)) : longint'($signed(b.min_x));
                py = (k & 2) ? longint'($signed(b.max_y)) : longint'($signed(b.min_y));
                pz = (k & 4) ? longint'($signed(b.max_z)) : longint'($signed(b.min_z));
                if (nx * px + ny * py + nz * pz + dd >= 0) begin
                    behind = 1'b0;
                end
            end
            if (behind) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [15:0] clamp16(input int v);
        if (v > 32767) begin
            return 16'h7fff;
        end else if (v < -32768) begin
            return 16'h8000;
        end
        return 16'(v);
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'hffff;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'h7fff;
        endcase
    endfunction

    function automatic logic [63:0] pack_plane(input int nx, input int ny, input int nz,
                                               input int d);
        return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    // planes come in pairs per axis: n = +1 keeps coord >= -half, n = -1 keeps coord <= half
    function automatic logic [63:0] frustum_plane(input int p, input int half);
        int n;
        n = (p % 2) ? -ONE_Q14 : ONE_Q14;
        case (p / 2)
            0: return pack_plane(n, 0, 0, half);
            1: return pack_plane(0, n, 0, half);
            default: return pack_plane(0, 0, n, half);
        endcase
    endfunction

    function automatic t_box_in make_box(input int lx, input int ly, input int lz,
                                         input int hx, input int hy, input int hz,
                                         input bit last);
        t_box_in b;
        b.min_x = clamp16(lx);
        b.min_y = clamp16(ly);
        b.min_z = clamp16(lz);
        b.max_x = clamp16(hx);
        b.max_y = clamp16(hy);
        b.max_z = clamp16(hz);
        b.last_box = last;
        return b;
    endfunction

    // mostly well-formed boxes centred within the reach, some swapped, raw or extreme
    function automatic t_box_in random_box(input int reach);
        t_box_in     b;
        logic [15:0] lo [3];
        logic [15:0] hi [3];
        logic [15:0] t;
        int          mid, half, kind, axis;
        kind = $urandom_range(0, 9);
        for (int a = 0; a < 3; a++) begin
            mid = int'($urandom_range(0, 2 * reach)) - reach;
            half = $urandom_range(0, reach / 4 + 1);
            lo[a] = clamp16(mid - half);
            hi[a] = clamp16(mid + half);
            if (kind == 8) begin
                lo[a] = 16'($urandom);
                hi[a] = 16'($urandom);
            end else if (kind == 9) begin
                lo[a] = pick_extreme();
                hi[a] = pick_extreme();
            end
        end
        if (kind == 7) begin
            axis = $urandom_range(0, 2);
            t = lo[axis];
            lo[axis] = hi[axis];
            hi[axis] = t;
        end
        b.min_x = lo[0];
        b.min_y = lo[1];
        b.min_z = lo[2];
        b.max_x = hi[0];
        b.max_y = hi[1];
        b.max_z = hi[2];
        b.last_box = ($urandom_range(0, 7) == 0);
        return b;
    endfunction

    task automatic write_plane(input int idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'(idx * PLANE_ADDR_STEP);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < PLANE_SLOTS) begin
            plane_regs[idx] = value;
        end
    endtask

    task automatic load_planes(input t_plane_mix mix, output int reach);
        logic [63:0] value;
        int          half;
        half = $urandom_range(16, 8000);
        reach = (mix == PLANES_FRUSTUM) ? 2 * half : 32767;
        for (int p = 0; p < PLANE_SLOTS; p++) begin
            case (mix)
                PLANES_FRUSTUM: value = frustum_plane(p, half);
                PLANES_RANDOM: begin
                    value = ($urandom_range(0, 2) == 0) ? 64'd0 : {$urandom, $urandom};
                end
                default: value = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme()};
            endcase
            write_plane(p, value);
        end
    endtask

    task automatic drain();
        while (box_queue.size() != 0 || i_in_valid || cull_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // sender: holds each item until taken, random gaps between items when send_idle is set
    always @(posedge i_clk) begin : box_driver
        t_box_out predicted;
        int       send_gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (in_fire) begin
                predicted.culled      = box_is_culled(i_in_item);
                predicted.last_result = i_in_item.last_box;
                cull_expect.push_back(predicted);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (box_queue.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (send_idle && $urandom_range(0, 9) == 0) begin
                    send_gap = $urandom_range(0, 10);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_item  <= box_queue.pop_front();
                end
            end
        end
    end

    // receiver: checks each result, stalls in bursts when recv_idle is set, one long hold on request
    always @(posedge i_clk) begin : result_monitor
        t_box_out want;
        int       recv_gap;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (out_fire) begin
                if (cull_expect.size() == 0) begin
                    $display("%0t ns: unexpected item, actual culled %0b last %0b",
                             $time, o_out_item.culled, o_out_item.last_result);
                    error_count++;
                end else begin
                    want = cull_expect.pop_front();
                    if (o_out_item.culled !== want.culled) begin
                        $display("%0t ns: culled mismatch, expected %0b, actual %0b",
                                 $time, want.culled, o_out_item.culled);
                        error_count++;
                    end
                    if (o_out_item.last_result !== want.last_result) begin
                        $display("%0t ns: last_result mismatch, expected %0b, actual %0b",
                                 $time, want.last_result, o_out_item.last_result);
                        error_count++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                recv_gap = LONG_HOLD;
            end
            if (recv_gap > 0) begin
                recv_gap = recv_gap - 1;
                i_out_ready <= 1'b0;
            end else if (recv_idle && $urandom_range(0, 9) == 0) begin
                recv_gap = $urandom_range(0, 10);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        quiet_cycles <= (in_fire || out_fire || !i_rst_n) ? 0 : quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int         reach;
        t_plane_mix mix;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        for (int p = 0; p < PLANE_SLOTS; p++) begin
            plane_regs[p] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // planes at reset are all zero: distance zero everywhere, nothing culled
        box_queue.push_back(make_box(-32768, -32768, -32768, -32768, -32768, -32768, 1'b0));
        box_queue.push_back(make_box(32767, 32767, 32767, 32767, 32767, 32767, 1'b1));
        box_queue.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0));
        box_queue.push_back(make_box(32767, 100, -5, -32768, -100, 5, 1'b1));
        drain();

        // axis box of half size 1600, spare register slots written with junk
        for (int p = 0; p < PLANE_SLOTS; p++) begin
            write_plane(p, frustum_plane(p, 1600));
        end
        write_plane(REG_SPARE_SIX, {$urandom, $urandom});
        write_plane(REG_SPARE_SEVEN, {$urandom, $urandom});
        box_queue.push_back(make_box(-16, -16, -16, 16, 16, 16, 1'b0));
        box_queue.push_back(make_box(-3200, -10, -10, -1600, 10, 10, 1'b0));
        box_queue.push_back(make_box(-3200, -10, -10, -1601, 10, 10, 1'b1));
        box_queue.push_back(make_box(1600, -10, -10, 3200, 10, 10, 1'b0));
        box_queue.push_back(make_box(1601, -10, -10, 3200, 10, 10, 1'b0));
        box_queue.push_back(make_box(-10, 1601, -10, 10, 2000, 10, 1'b0));
        box_queue.push_back(make_box(-10, -10, -9000, 10, 10, -1601, 1'b1));
        box_queue.push_back(make_box(500, 500, 500, -500, -500, -500, 1'b0));
        box_queue.push_back(make_box(-1700, 0, 0, -2000, 0, 0, 1'b0));
        box_queue.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b1));
        box_queue.push_back(make_box(32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
        box_queue.push_back(make_box(-32768, 0, 0, -32768, 0, 0, 1'b1));
        drain();

        // extreme normals and distances
        write_plane(0, pack_plane(-32768, -32768, -32768, 32767));
        write_plane(1, pack_plane(32767, 32767, 32767, -32768));
        write_plane(2, pack_plane(32767, -32768, 1, -1));
        write_plane(3, pack_plane(-1, 1, -32768, 32767));
        write_plane(4, 64'd0);
        write_plane(5, pack_plane(0, 0, 0, -32768));
        box_queue.push_back(make_box(32767, 32767, 32767, 32767, 32767, 32767, 1'b0));
        box_queue.push_back(make_box(-32768, -32768, -32768, -32768, -32768, -32768, 1'b1));
        box_queue.push_back(make_box(-32768, -32768, -32768, 32767, 32767, 32767, 1'b0));
        box_queue.push_back(make_box(0, 0, 0, 0, 0, 0, 1'b1));
        box_queue.push_back(make_box(-1, -1, -1, -1, -1, -1, 1'b0));
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mix = t_plane_mix'(ph % 3);
            load_planes(mix, reach);
            send_idle = (ph < RANDOM_PHASES - 2);
            recv_idle = (ph < RANDOM_PHASES - 2);
            if (ph == PRESSURE_PHASE) begin
                send_idle = 1'b0;
                hold_request = 1'b1;
            end
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                box_queue.push_back(random_box(reach));
            end
            drain();
        end

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/aabbfc_pkg.sv
hw/rtl/aabbfc_cell.sv
hw/rtl/aabb_frustum_cull.sv
test/testbench.sv
